/* src/pcf_pkg.sv */
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and helper functions of the PNG chunk framer.
// ----------------------------------------------------------------------------
package pcf_pkg;

	localparam int FUNC_W = 2;
	localparam int LEN_W  = 31;
	localparam int TYPE_W = 32;
	localparam int BYTE_W = 8;
	localparam int CRC_W  = 32;

	// command queue depth
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFFFFFF;

	typedef enum logic [FUNC_W-1:0] {
		FN_SIG  = 2'd0,
		FN_HDR  = 2'd1,
		FN_DATA = 2'd2,
		FN_RSVD = 2'd3
	} func_t;

	// byte index within one command's output run
	typedef logic [3:0] step_t;

	localparam step_t STEP_FIRST     = 4'd0;
	localparam step_t SIG_LAST       = 4'd7;
	localparam step_t HDR_TYPE_FIRST = 4'd4;
	localparam step_t HDR_TYPE_LAST  = 4'd7;
	localparam step_t HDR_CRC_LAST   = 4'd11;
	localparam step_t DATA_CRC_LAST  = 4'd4;

	typedef struct packed {
		func_t              func;
		logic [LEN_W-1:0]   chunk_length;
		logic [TYPE_W-1:0]  chunk_type;
		logic [BYTE_W-1:0]  data_byte;
	} job_t;

	localparam logic [BYTE_W-1:0] PNG_SIG [8] = '{
		8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
	};

	function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
		return PNG_SIG[idx];
	endfunction

	// big-endian byte pick: sel 0 is the top byte
	function automatic logic [BYTE_W-1:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
		logic [BYTE_W-1:0] r;
		case (sel)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	// reflected CRC-32, one byte folded bit by bit
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] c,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] r;
		r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

/* src/pcf_cmd_if.sv */
// ----------------------------------------------------------------------------
// pcf_cmd_if
// Command channel of the framer: valid/ready plus one command word.
// ----------------------------------------------------------------------------
interface pcf_cmd_if;
	import pcf_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [LEN_W-1:0]  chunk_length;
	logic [TYPE_W-1:0] chunk_type;
	logic [BYTE_W-1:0] data_byte;

	modport source(output valid, output func, output chunk_length, output chunk_type,
		output data_byte, input ready);
	modport sink(input valid, input func, input chunk_length, input chunk_type,
		input data_byte, output ready);
endinterface

/* src/pcf_byte_if.sv */
// ----------------------------------------------------------------------------
// pcf_byte_if
// Byte stream channel of the framer: valid/ready plus one stream word.
// ----------------------------------------------------------------------------
interface pcf_byte_if;
	import pcf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic              chunk_done;

	modport source(output valid, output out_byte, output run_last, output chunk_done,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input chunk_done,
		output ready);
endinterface

/* src/png_chunk_framer.sv */
// ----------------------------------------------------------------------------
// png_chunk_framer
// Turns signature, chunk header and data byte commands into a PNG byte
// stream with big-endian lengths and a reflected CRC-32 trailer per chunk.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                        | word
//  --------+-----+------------------------------------------------+----------------
//  cmd     | in  | func, chunk_length, chunk_type, data_byte      | one command
//  strm    | out | out_byte, run_last, chunk_done                 | one stream byte
//
// Output: one byte per cycle through the output register while strm takes it. A
// data byte yields one byte (five when it closes the chunk), a signature eight,
// a header eight (twelve for zero length); stray data and the unused code none.
// Reset: asynchronous, clears queue pointers, sequencer and chunk context.
// Stalls: a 4-deep command queue takes commands while bytes of earlier ones
// drain; a stalled strm freezes the sequencer with its output held.
//
module png_chunk_framer (
	input  logic clk,
	input  logic arst_n,
	pcf_cmd_if.sink   cmd,
	pcf_byte_if.source strm
);
	import pcf_pkg::*;

	// command queue
	logic  q_push;
	job_t  q_in;
	logic  q_full;
	logic  hv;
	job_t  hd;
	logic  h_take;

	assign cmd.ready = !q_full;
	assign q_push    = cmd.valid && !q_full;

	always_comb begin
		q_in.func         = func_t'(cmd.func);
		q_in.chunk_length = cmd.chunk_length;
		q_in.chunk_type   = cmd.chunk_type;
		q_in.data_byte    = cmd.data_byte;
	end

	pcf_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_in),
		.full       (q_full),
		.head_valid (hv),
		.head       (hd),
		.head_take  (h_take)
	);

	// chunk context and sequencer state
	logic [CRC_W-1:0]  crc_q;
	logic [LEN_W-1:0]  rem_q;
	logic              open_q;
	step_t             step_q;

	// output register
	logic              ob_valid_q;
	logic [BYTE_W-1:0] ob_byte_q;
	logic              ob_last_q;
	logic              ob_done_q;

	logic              adv;
	logic              emit;
	logic              skip;
	logic              fire;
	logic              last;
	logic              done;
	logic [BYTE_W-1:0] byte_d;
	logic [BYTE_W-1:0] tbyte;
	logic [CRC_W-1:0]  crc_d;
	logic [LEN_W-1:0]  rem_d;
	logic              open_d;
	logic [1:0]        tsel;

	assign adv = !ob_valid_q || strm.ready;

	always_comb begin
		emit   = 1'b0;
		skip   = 1'b0;
		last   = 1'b0;
		done   = 1'b0;
		byte_d = '0;
		crc_d  = crc_q;
		rem_d  = rem_q;
		open_d = open_q;
		tbyte  = be_byte(hd.chunk_type, step_q[1:0]);
		tsel   = 2'(step_q - 4'd1);
		if (hv) begin
			case (hd.func)
				FN_SIG: begin
					emit   = 1'b1;
					byte_d = sig_byte(step_q[2:0]);
					last   = (step_q == SIG_LAST);
				end
				FN_HDR: begin
					emit = 1'b1;
					if (step_q < HDR_TYPE_FIRST) begin
						byte_d = be_byte({1'b0, hd.chunk_length}, step_q[1:0]);
					end else if (step_q <= HDR_TYPE_LAST) begin
						// type bytes seed the CRC; preset on the first one
						byte_d = tbyte;
						crc_d  = crc_fold((step_q == HDR_TYPE_FIRST) ? CRC_PRESET : crc_q,
							tbyte);
						if (step_q == HDR_TYPE_LAST) begin
							rem_d  = hd.chunk_length;
							open_d = 1'b1;
						end
					end else begin
						// zero-length chunk: trailer right after the header
						byte_d = be_byte(~crc_q, step_q[1:0]);
						if (step_q == HDR_CRC_LAST) begin
							done   = 1'b1;
							open_d = 1'b0;
							rem_d  = '0;
						end
					end
					last = (hd.chunk_length == '0) ? (step_q == HDR_CRC_LAST)
						: (step_q == HDR_TYPE_LAST);
				end
				FN_DATA: begin
					if (step_q == STEP_FIRST) begin
						if (!open_q || rem_q == '0) begin
							skip = 1'b1;
						end else begin
							emit   = 1'b1;
							byte_d = hd.data_byte;
							crc_d  = crc_fold(crc_q, hd.data_byte);
							rem_d  = rem_q - 1'b1;
							last   = (rem_q != LEN_W'(1));
						end
					end else begin
						// closing trailer, one CRC byte per step
						emit   = 1'b1;
						byte_d = be_byte(~crc_q, tsel);
						if (step_q == DATA_CRC_LAST) begin
							last   = 1'b1;
							done   = 1'b1;
							open_d = 1'b0;
							rem_d  = '0;
						end
					end
				end
				default: begin
					skip = 1'b1;
				end
			endcase
		end
	end

	assign fire   = emit && adv;
	assign h_take = skip || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_PRESET;
			rem_q      <= '0;
			open_q     <= 1'b0;
			step_q     <= STEP_FIRST;
			ob_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				crc_q      <= crc_d;
				rem_q      <= rem_d;
				open_q     <= open_d;
				step_q     <= last ? STEP_FIRST : step_q + 1'b1;
				ob_valid_q <= 1'b1;
			end else if (strm.ready) begin
				ob_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ob_byte_q <= byte_d;
			ob_last_q <= last;
			ob_done_q <= done;
		end
	end

	assign strm.valid      = ob_valid_q;
	assign strm.out_byte   = ob_byte_q;
	assign strm.run_last   = ob_last_q;
	assign strm.chunk_done = ob_done_q;

endmodule

/* src/pcf_job_fifo.sv */
// ----------------------------------------------------------------------------
// pcf_job_fifo
// Command queue in a synchronous RAM; the read data register is the head.
// ----------------------------------------------------------------------------
module pcf_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcf_pkg::job_t push_job,
	output logic          full,
	output logic          head_valid,
	output pcf_pkg::job_t head,
	input  logic          head_take
);
	import pcf_pkg::*;

	job_t           mem [QDEPTH];
	logic [QAW:0]   wr_ptr_q;
	logic [QAW:0]   rd_ptr_q;
	logic           head_valid_q;
	job_t           head_q;
	logic [QAW:0]   count;
	logic           empty;
	logic           pop;

	assign count = wr_ptr_q - rd_ptr_q;
	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (count == (QAW+1)'(QDEPTH));
	// refill head when it is free or leaves this cycle
	assign pop   = !empty && (!head_valid_q || head_take);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q[QAW-1:0]] <= push_job;
		end
		if (pop) begin
			head_q <= mem[rd_ptr_q[QAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			head_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q     <= rd_ptr_q + 1'b1;
				head_valid_q <= 1'b1;
			end else if (head_take) begin
				head_valid_q <= 1'b0;
			end
		end
	end

	assign head_valid = head_valid_q;
	assign head       = head_q;

endmodule
